// File: src/vertex_diffuse_shade_macros.svh
// Assertion macros for the vertex_diffuse_shade checker.
// Clocked on clock, disabled while reset is high.
`ifndef VERTEX_DIFFUSE_SHADE_MACROS_SVH
`define VERTEX_DIFFUSE_SHADE_MACROS_SVH

// common clocking and reset for every property
`define VDS_CLOCKING @(posedge clock) disable iff (reset)

// labeled concurrent assertion that reports through $error
`define VDS_ASSERT(lbl, prop, msg) \
   lbl: assert property (`VDS_CLOCKING prop) else $error(msg);

`endif

// File: src/vds_pkg.sv
// Package for vertex_diffuse_shade: widths, codes, shared types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package vds_pkg;

   localparam int COEFF_W  = 16;               // coeff, normal, light direction
   localparam int ROT_W    = 32;               // rotated light entry
   localparam int PROD_W   = COEFF_W + ROT_W;  // one multiplier product
   localparam int ACC_W    = PROD_W + 2;       // sum of three products
   localparam int DIV_W    = 32;               // divider magnitudes
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam int DOT_SHIFT = 16;
   localparam int TERM_W   = ACC_W - DOT_SHIFT;
   localparam int SUM_W    = TERM_W + 2;
   localparam int SHADE_W  = 13;
   localparam int SHADE_LIMIT   = 8191;
   localparam int NEUTRAL_SHADE = 4096;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int AXIS_W   = 2;
   localparam int NUM_AXES = 3;

   // request command codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_VERTEX = 1'b1;

   // axis code that selects no entry
   localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHTING_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_NORMALS     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_ADDER     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_DIVIDER   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_DIR_X     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_DIR_Y     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_DIR_Z     = 3'd6;

   // control from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic clear;   // zero the accumulator
      logic issue;   // operands valid this cycle
   } mac_ctrl_type;

endpackage

// File: src/vds_mac.sv
// Shared signed 16x32 multiplier with registered product and accumulator.
// Depends on vds_pkg.
`timescale 1ns / 1ps

module vds_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  vds_pkg::mac_ctrl_type             ctrl,
   input  logic signed [vds_pkg::COEFF_W-1:0] a_op,
   input  logic signed [vds_pkg::ROT_W-1:0]   b_op,
   output logic signed [vds_pkg::ACC_W-1:0]   acc
);

   logic signed [vds_pkg::PROD_W-1:0] prod_in;
   logic signed [vds_pkg::PROD_W-1:0] prod_ff;
   logic                              prod_valid_in;
   logic                              prod_valid_ff;
   logic signed [vds_pkg::ACC_W-1:0]  acc_in;
   logic signed [vds_pkg::ACC_W-1:0]  acc_ff;

   assign prod_in       = vds_pkg::PROD_W'(a_op) * vds_pkg::PROD_W'(b_op);
   assign prod_valid_in = ctrl.issue;

   always_comb begin
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + vds_pkg::ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// File: src/vds_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on vds_pkg.
`timescale 1ns / 1ps

module vds_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [vds_pkg::DIV_W-1:0] dividend,
   input  logic [vds_pkg::DIV_W-1:0] divisor,
   output logic                      done,
   output logic [vds_pkg::DIV_W-1:0] quotient
);

   logic                          busy_in, busy_ff;
   logic                          done_in, done_ff;
   logic [vds_pkg::DIV_CNT_W-1:0] cnt_in, cnt_ff;
   logic [vds_pkg::DIV_W-1:0]     rem_in, rem_ff;
   logic [vds_pkg::DIV_W-1:0]     quo_in, quo_ff;
   logic [vds_pkg::DIV_W-1:0]     dvs_in, dvs_ff;
   logic [vds_pkg::DIV_W:0]       rem_shift;
   logic [vds_pkg::DIV_W:0]       diff;

   assign rem_shift = {rem_ff, quo_ff[vds_pkg::DIV_W-1]};
   assign diff      = rem_shift - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // borrow out means the trial subtract failed
         if (!diff[vds_pkg::DIV_W]) begin
            rem_in = diff[vds_pkg::DIV_W-1:0];
            quo_in = {quo_ff[vds_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[vds_pkg::DIV_W-1:0];
            quo_in = {quo_ff[vds_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == vds_pkg::DIV_CNT_W'(vds_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: src/vertex_diffuse_shade.sv
// Top level: sequencer, registers, rotated light store and result register.
// Depends on vds_pkg, vds_mac and vds_div.
`timescale 1ns / 1ps
//
//  channel   ports    direction  carries
//  request   req_*    in         command, axis, coeff_a..c, normal_x..z,
//                                static_light, vertex_last
//  response  rsp_*    out        shade, shade_last (vertex requests only)
//  csr       csr_*    in         write enable, index, data; no read-back
//
// Vertex with lighting and normals on and a nonzero divider: three products
// through the one multiplier, one accumulate and one finish before the next
// accept. Other vertices go straight to the finish. Loads run the same products
// and then the bit-serial divider; loads with axis 3 or a zero divider do not stall.
// Reset clears registers to their defaults and the rotated light to zero.
// A stalled response holds in the output register; the block keeps taking
// requests until a second shade has to wait for it.

module vertex_diffuse_shade (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic [vds_pkg::AXIS_W-1:0]           req_axis,
   input  logic signed [vds_pkg::COEFF_W-1:0]   req_coeff_a,
   input  logic signed [vds_pkg::COEFF_W-1:0]   req_coeff_b,
   input  logic signed [vds_pkg::COEFF_W-1:0]   req_coeff_c,
   input  logic signed [vds_pkg::COEFF_W-1:0]   req_normal_x,
   input  logic signed [vds_pkg::COEFF_W-1:0]   req_normal_y,
   input  logic signed [vds_pkg::COEFF_W-1:0]   req_normal_z,
   input  logic signed [vds_pkg::COEFF_W-1:0]   req_static_light,
   input  logic                                 req_vertex_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [vds_pkg::SHADE_W-1:0]          rsp_shade,
   output logic                                 rsp_shade_last,
   input  logic                                 csr_we,
   input  logic [vds_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [vds_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_ACC,
      S_FIN,
      S_DIV
   } state_type;

   function automatic logic [vds_pkg::SHADE_W-1:0] clamp_shade(
      input logic signed [vds_pkg::SUM_W-1:0] v
   );
      logic [vds_pkg::SHADE_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed(vds_pkg::SUM_W'(vds_pkg::SHADE_LIMIT))) begin
         r = vds_pkg::SHADE_W'(vds_pkg::SHADE_LIMIT);
      end else begin
         r = v[vds_pkg::SHADE_W-1:0];
      end
      return r;
   endfunction

   state_type state_in, state_ff;
   logic [1:0] step_in, step_ff;

   // latched request
   logic                               cmd_in, cmd_ff;
   logic [vds_pkg::AXIS_W-1:0]         axis_in, axis_ff;
   logic signed [vds_pkg::COEFF_W-1:0] op_in [vds_pkg::NUM_AXES];
   logic signed [vds_pkg::COEFF_W-1:0] op_ff [vds_pkg::NUM_AXES];
   logic signed [vds_pkg::COEFF_W-1:0] static_in, static_ff;
   logic                               last_in, last_ff;

   // registers
   logic                               light_en_in, light_en_ff;
   logic                               use_norm_in, use_norm_ff;
   logic signed [vds_pkg::COEFF_W-1:0] adder_in, adder_ff;
   logic signed [vds_pkg::ROT_W-1:0]   divider_in, divider_ff;
   logic signed [vds_pkg::COEFF_W-1:0] dir_in [vds_pkg::NUM_AXES];
   logic signed [vds_pkg::COEFF_W-1:0] dir_ff [vds_pkg::NUM_AXES];

   logic signed [vds_pkg::ROT_W-1:0]   rot_in [vds_pkg::NUM_AXES];
   logic signed [vds_pkg::ROT_W-1:0]   rot_ff [vds_pkg::NUM_AXES];

   logic                               rsp_valid_in, rsp_valid_ff;
   logic [vds_pkg::SHADE_W-1:0]        rsp_shade_in, rsp_shade_ff;
   logic                               rsp_last_in, rsp_last_ff;

   // datapath
   vds_pkg::mac_ctrl_type              mac_ctrl;
   logic signed [vds_pkg::COEFF_W-1:0] a_op;
   logic signed [vds_pkg::ROT_W-1:0]   b_op;
   logic signed [vds_pkg::ACC_W-1:0]   acc;
   logic                               div_start;
   logic                               div_done;
   logic [vds_pkg::DIV_W-1:0]          quotient;
   logic                               num_neg, dvs_neg, q_neg;
   logic [vds_pkg::ACC_W-1:0]          num_abs;
   logic [vds_pkg::DIV_W-1:0]          num_mag, dvs_mag, quo_neg;
   logic signed [vds_pkg::ROT_W-1:0]   quo_sat;
   logic signed [vds_pkg::SUM_W-1:0]   adder_ext, term_ext, static_ext, sum;
   logic [vds_pkg::SHADE_W-1:0]        shade;
   logic                               req_accept;
   logic                               rsp_free;

   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // multiplier operands: coeff x light dir on loads, normal x rotated on vertices
   assign a_op = op_ff[step_ff];
   assign b_op = (cmd_ff == vds_pkg::CMD_VERTEX) ? rot_ff[step_ff]
                                                 : vds_pkg::ROT_W'(dir_ff[step_ff]);

   vds_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .a_op  (a_op),
      .b_op  (b_op),
      .acc   (acc)
   );

   // sign-magnitude around the unsigned divider
   assign num_neg = acc[vds_pkg::ACC_W-1];
   assign num_abs = num_neg ? -acc : acc;
   assign num_mag = num_abs[vds_pkg::DIV_W-1:0];
   assign dvs_neg = divider_ff[vds_pkg::ROT_W-1];
   assign dvs_mag = dvs_neg ? vds_pkg::DIV_W'(-divider_ff) : vds_pkg::DIV_W'(divider_ff);
   assign q_neg   = num_neg ^ dvs_neg;
   assign quo_neg = -quotient;

   vds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_mag),
      .divisor  (dvs_mag),
      .done     (div_done),
      .quotient (quotient)
   );

   // saturate the quotient to the signed 32-bit range
   always_comb begin
      if (!q_neg && quotient[vds_pkg::DIV_W-1]) begin
         quo_sat = {1'b0, {(vds_pkg::ROT_W-1){1'b1}}};
      end else if (q_neg && quotient > {1'b1, {(vds_pkg::DIV_W-1){1'b0}}}) begin
         quo_sat = {1'b1, {(vds_pkg::ROT_W-1){1'b0}}};
      end else if (q_neg) begin
         quo_sat = $signed(quo_neg);
      end else begin
         quo_sat = $signed(quotient);
      end
   end

   // shade: floor(dot / 2^16) is an arithmetic shift of the accumulator
   assign adder_ext  = vds_pkg::SUM_W'(adder_ff);
   assign static_ext = vds_pkg::SUM_W'(static_ff);
   assign term_ext   = vds_pkg::SUM_W'($signed(acc[vds_pkg::ACC_W-1:vds_pkg::DOT_SHIFT]));

   always_comb begin
      if (!use_norm_ff) begin
         sum = adder_ext + static_ext;
      end else if (divider_ff == '0) begin
         sum = adder_ext;
      end else begin
         sum = adder_ext + term_ext;
      end
      if (!light_en_ff) begin
         shade = vds_pkg::SHADE_W'(vds_pkg::NEUTRAL_SHADE);
      end else begin
         shade = clamp_shade(sum);
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd_in       = cmd_ff;
      axis_in      = axis_ff;
      op_in        = op_ff;
      static_in    = static_ff;
      last_in      = last_ff;
      light_en_in  = light_en_ff;
      use_norm_in  = use_norm_ff;
      adder_in     = adder_ff;
      divider_in   = divider_ff;
      dir_in       = dir_ff;
      rot_in       = rot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_shade_in = rsp_shade_ff;
      rsp_last_in  = rsp_last_ff;
      mac_ctrl     = '0;
      div_start    = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            vds_pkg::CSR_LIGHTING_ENABLE: light_en_in = csr_wdata[0];
            vds_pkg::CSR_USE_NORMALS:     use_norm_in = csr_wdata[0];
            vds_pkg::CSR_LIGHT_ADDER:     adder_in    = csr_wdata[vds_pkg::COEFF_W-1:0];
            vds_pkg::CSR_LIGHT_DIVIDER:   divider_in  = csr_wdata[vds_pkg::ROT_W-1:0];
            vds_pkg::CSR_LIGHT_DIR_X:     dir_in[0]   = csr_wdata[vds_pkg::COEFF_W-1:0];
            vds_pkg::CSR_LIGHT_DIR_Y:     dir_in[1]   = csr_wdata[vds_pkg::COEFF_W-1:0];
            vds_pkg::CSR_LIGHT_DIR_Z:     dir_in[2]   = csr_wdata[vds_pkg::COEFF_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in    = req_command;
               axis_in   = req_axis;
               static_in = req_static_light;
               last_in   = req_vertex_last;
               step_in   = '0;
               mac_ctrl.clear = 1'b1;
               if (req_command == vds_pkg::CMD_VERTEX) begin
                  op_in[0] = req_normal_x;
                  op_in[1] = req_normal_y;
                  op_in[2] = req_normal_z;
                  if (light_en_ff && use_norm_ff && divider_ff != '0) begin
                     state_in = S_MUL;
                  end else begin
                     state_in = S_FIN;
                  end
               end else begin
                  op_in[0] = req_coeff_a;
                  op_in[1] = req_coeff_b;
                  op_in[2] = req_coeff_c;
                  if (req_axis == vds_pkg::AXIS_NONE) begin
                     state_in = S_IDLE;
                  end else if (divider_ff == '0) begin
                     for (int i = 0; i < vds_pkg::NUM_AXES; i++) begin
                        if (req_axis == vds_pkg::AXIS_W'(i)) begin
                           rot_in[i] = '0;
                        end
                     end
                  end else begin
                     state_in = S_MUL;
                  end
               end
            end
         end
         S_MUL: begin
            mac_ctrl.issue = 1'b1;
            if (step_ff == 2'(vds_pkg::NUM_AXES - 1)) begin
               step_in  = '0;
               state_in = S_ACC;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_ACC: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (cmd_ff == vds_pkg::CMD_LOAD) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_shade_in = shade;
               rsp_last_in  = last_ff;
               state_in     = S_IDLE;
            end
         end
         S_DIV: begin
            if (div_done) begin
               for (int i = 0; i < vds_pkg::NUM_AXES; i++) begin
                  if (axis_ff == vds_pkg::AXIS_W'(i)) begin
                     rot_in[i] = quo_sat;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         light_en_ff  <= 1'b1;
         use_norm_ff  <= 1'b1;
         adder_ff     <= '0;
         divider_ff   <= '0;
         dir_ff       <= '{default: '0};
         rot_ff       <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         light_en_ff  <= light_en_in;
         use_norm_ff  <= use_norm_in;
         adder_ff     <= adder_in;
         divider_ff   <= divider_in;
         dir_ff       <= dir_in;
         rot_ff       <= rot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      axis_ff      <= axis_in;
      op_ff        <= op_in;
      static_ff    <= static_in;
      last_ff      <= last_in;
      rsp_shade_ff <= rsp_shade_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_shade      = rsp_shade_ff;
   assign rsp_shade_last = rsp_last_ff;

endmodule

// File: src/vds_checker.sv
// Port-level checker for vertex_diffuse_shade, bound to the top level.
// Depends on vds_pkg and vertex_diffuse_shade_macros.svh.
`timescale 1ns / 1ps
`include "vertex_diffuse_shade_macros.svh"

module vds_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         req_command,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [vds_pkg::SHADE_W-1:0]  rsp_shade
);

   // a stalled response stays offered
   `VDS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "response dropped under stall")

   // a stalled shade does not change
   `VDS_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(rsp_shade), "stalled shade changed")

   // an accepted vertex always drives the block busy and stalls further requests
   `VDS_ASSERT(a_vertex_busy, req_valid && !req_stall && req_command == vds_pkg::CMD_VERTEX |=> req_stall, "vertex request not held busy")

   // a new response is only loaded while a request is being worked on
   `VDS_ASSERT(a_rsp_source, $rose(rsp_valid) |-> $past(req_stall), "response without a request in flight")

endmodule

bind vertex_diffuse_shade vds_checker u_vds_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_command (req_command),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_shade   (rsp_shade)
);
